[src/qsi_pkg.sv]
// Shared types, widths and constants of the quintic segment interpolator.
package qsi_pkg;

    localparam int POS_W         = 24;
    localparam int ANG_W         = 16;
    localparam int SPD_W         = 24;
    localparam int STEP_W        = 6;
    localparam int MAX_STEPS_DEF = 63;
    localparam int STEPS_RESET   = 10;
    localparam int TRIG_W        = 18;
    localparam int CXY_W         = 20;
    localparam int CZ_W          = 18;
    localparam int CORDIC_ROUNDS = 16;
    localparam int CORDIC_GAIN   = 39797;
    localparam int TRIG_ONE      = 65536;
    localparam int QUARTER_TURN  = 16384;
    localparam int HALF_TURN     = 32768;
    localparam int TRIG_FRAC     = 16;
    localparam int VEL_W         = 26;
    localparam int COEF_W        = 40;
    localparam int MUL_W         = 33;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int WGT_W         = 30;
    localparam int QUO_W         = 36;
    localparam int SUM_W         = QUO_W + 2;
    localparam int STORE_DEPTH   = 10;
    localparam int AXIS_TERMS    = 5;

    typedef logic [STEP_W-1:0] steps_t;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_y;
        logic signed [ANG_W-1:0] start_heading;
        logic signed [ANG_W-1:0] end_heading;
        logic [SPD_W-1:0]        start_speed;
        logic [SPD_W-1:0]        end_speed;
        logic                    include_end;
    } seg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] point_x;
        logic signed [POS_W-1:0] point_y;
        logic                    last_point;
    } point_t;

    function automatic logic [13:0] atan_units(input logic [3:0] k);
        logic [13:0] r;
        begin
            case (k)
                4'd0:    r = 14'd8192;
                4'd1:    r = 14'd4836;
                4'd2:    r = 14'd2555;
                4'd3:    r = 14'd1297;
                4'd4:    r = 14'd651;
                4'd5:    r = 14'd326;
                4'd6:    r = 14'd163;
                4'd7:    r = 14'd81;
                4'd8:    r = 14'd41;
                4'd9:    r = 14'd20;
                4'd10:   r = 14'd10;
                4'd11:   r = 14'd5;
                4'd12:   r = 14'd3;
                4'd13:   r = 14'd1;
                4'd14:   r = 14'd1;
                default: r = 14'd0;
            endcase
            return r;
        end
    endfunction

endpackage

[src/qsi_stream_if.sv]
// Valid/ready channel interface carrying one request payload.
interface qsi_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[src/qsi_cordic.sv]
// Iterative CORDIC unit giving sine and cosine of a binary angle.
module qsi_cordic
    import qsi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ANG_W-1:0]  angle,
    output logic                     done,
    output logic signed [TRIG_W-1:0] sin_val,
    output logic signed [TRIG_W-1:0] cos_val
);

    logic signed [CXY_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [CZ_W-1:0]   z_reg, z_next;
    logic [3:0]               k_reg;
    logic                     busy_reg, neg_reg, done_reg;
    logic signed [TRIG_W-1:0] sin_reg, cos_reg;
    logic signed [CZ_W-1:0]   ang_ext, fold_z, atan_ext;
    logic                     fold_neg;
    logic signed [CXY_W-1:0]  fx, fy;

    function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [CXY_W-1:0] v);
        logic signed [TRIG_W-1:0] r;
        begin
            if (v > CXY_W'(TRIG_ONE))
                r = TRIG_W'(TRIG_ONE);
            else if (v < -CXY_W'(TRIG_ONE))
                r = -TRIG_W'(TRIG_ONE);
            else
                r = TRIG_W'(v);
            return r;
        end
    endfunction

    always_comb
    begin
        ang_ext  = CZ_W'(angle);
        fold_neg = 1'b0;
        fold_z   = ang_ext;
        if (ang_ext > CZ_W'(QUARTER_TURN))
        begin
            fold_z   = ang_ext - CZ_W'(HALF_TURN);
            fold_neg = 1'b1;
        end
        else if (ang_ext < -CZ_W'(QUARTER_TURN))
        begin
            fold_z   = ang_ext + CZ_W'(HALF_TURN);
            fold_neg = 1'b1;
        end
        atan_ext = CZ_W'(atan_units(k_reg));
        if (z_reg >= 0)
        begin
            x_next = x_reg - (y_reg >>> k_reg);
            y_next = y_reg + (x_reg >>> k_reg);
            z_next = z_reg - atan_ext;
        end
        else
        begin
            x_next = x_reg + (y_reg >>> k_reg);
            y_next = y_reg - (x_reg >>> k_reg);
            z_next = z_reg + atan_ext;
        end
        fx = neg_reg ? -x_next : x_next;
        fy = neg_reg ? -y_next : y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + 4'd1;
                if (k_reg == 4'(CORDIC_ROUNDS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= CXY_W'(CORDIC_GAIN);
            y_reg   <= '0;
            z_reg   <= fold_z;
            neg_reg <= fold_neg;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            if (k_reg == 4'(CORDIC_ROUNDS - 1))
            begin
                sin_reg <= clamp_trig(fy);
                cos_reg <= clamp_trig(fx);
            end
        end
    end

    assign done    = done_reg;
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

[src/qsi_mul.sv]
// Shared signed multiplier with a registered product.
module qsi_mul
    import qsi_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

[src/qsi_div.sv]
// Bit-serial restoring divider with round-half-away-from-zero quotient.
module qsi_div
    import qsi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [PROD_W-1:0] num,
    input  logic [WGT_W-1:0]         den,
    output logic                     done,
    output logic signed [QUO_W:0]    quo
);

    localparam int CNT_W = $clog2(QUO_W);

    logic [PROD_W-1:0] mag;
    logic [QUO_W-1:0]  q_reg;
    logic [WGT_W-1:0]  rem_reg, den_reg;
    logic [WGT_W:0]    trial;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg, neg_reg, fits;

    always_comb
    begin
        mag   = (num < 0) ? PROD_W'(-num) : PROD_W'(num);
        mag   = mag + PROD_W'(den >> 1);
        trial = {rem_reg, q_reg[QUO_W-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag[QUO_W-1:0];
            rem_reg <= WGT_W'(mag >> QUO_W);
            den_reg <= den;
            neg_reg <= num < 0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? WGT_W'(trial - {1'b0, den_reg}) : WGT_W'(trial);
            q_reg   <= {q_reg[QUO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

[src/quintic_segment_interpolator.sv]
// Top level: sequencer that interpolates one path segment into points.
//
//  Channel | Dir | Payload                                   | Request
//  seg     | in  | positions, headings, speeds, include_end  | one path segment
//  pt      | out | point_x, point_y, last_point              | one point
//  cfg     | in  | steps_per_segment                         | register write
//
// A segment's setup takes two CORDIC runs and seven products; each point
// then takes seven products for the weights and, per axis, four products
// and a divider run.
// The shared multiplier and the bit-serial divider set how long these take.
// Reset returns the sequencer to idle and steps_per_segment to 10.
// A point waits in the output register until taken; no new segment is
// accepted until the last point of the current one has been taken.
module quintic_segment_interpolator
    import qsi_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    qsi_stream_if.sink   seg,
    qsi_stream_if.source pt,
    qsi_stream_if.sink   cfg
);

    localparam int IDX_W = $clog2(MAX_STEPS + 1) + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CORD_S = 4'd1;
    localparam logic [3:0] S_CORD_E = 4'd2;
    localparam logic [3:0] S_SEG    = 4'd3;
    localparam logic [3:0] S_COEF   = 4'd4;
    localparam logic [3:0] S_PT     = 4'd5;
    localparam logic [3:0] S_AXIS   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]               state_reg;
    steps_t                   steps_reg;
    seg_t                     seg_reg;
    logic [STEP_W-1:0]        n_reg, n_clamp;
    logic [IDX_W-1:0]         count_reg, idx_reg;
    logic [2:0]               op_reg;
    logic                     ph_reg, axis_reg;
    logic signed [TRIG_W-1:0] sin_s_reg, cos_s_reg, sin_e_reg, cos_e_reg;
    logic signed [VEL_W-1:0]  vel_reg [4];
    logic [WGT_W-1:0]         pw_reg [3];
    logic [WGT_W-1:0]         w_reg [4];
    logic [WGT_W-1:0]         n2_reg, n4_reg, n5_reg;
    logic signed [COEF_W-1:0] coef_store [STORE_DEPTH];
    logic signed [PROD_W-1:0] acc_reg, acc_sum;
    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic                     last_reg, out_valid_reg;

    logic                     cord_start, cord_done;
    logic signed [ANG_W-1:0]  cord_angle;
    logic signed [TRIG_W-1:0] cord_sin, cord_cos;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start, div_done;
    logic signed [QUO_W:0]    quo;
    logic [3:0]               base_idx, term_idx;
    logic signed [SUM_W-1:0]  pt_sum;
    logic signed [POS_W-1:0]  pt_sat;
    logic signed [COEF_W-1:0] ux, vx, uy, vy;
    logic                     seg_acc;

    function automatic logic signed [MUL_W-1:0] uext(input logic [WGT_W-1:0] v);
        return MUL_W'(v);
    endfunction

    function automatic logic signed [VEL_W-1:0] round_vel(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] m;
        logic [VEL_W-1:0]  q;
        begin
            m = (p < 0) ? PROD_W'(-p) : PROD_W'(p);
            q = VEL_W'((m + PROD_W'(TRIG_ONE / 2)) >> TRIG_FRAC);
            return (p < 0) ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic logic signed [COEF_W-1:0] sx(input logic signed [VEL_W-1:0] v);
        return COEF_W'(v);
    endfunction

    qsi_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (cord_angle),
        .done    (cord_done),
        .sin_val (cord_sin),
        .cos_val (cord_cos)
    );

    qsi_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    qsi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_sum),
        .den   (n5_reg),
        .done  (div_done),
        .quo   (quo)
    );

    assign seg.ready = state_reg == S_IDLE;
    assign cfg.ready = 1'b1;
    assign seg_acc   = seg.valid && seg.ready;

    assign pt.valid           = out_valid_reg;
    assign pt.data.point_x    = px_reg;
    assign pt.data.point_y    = py_reg;
    assign pt.data.last_point = last_reg;

    always_comb
    begin
        if (steps_reg == '0)
            n_clamp = STEP_W'(1);
        else if (steps_reg > STEP_W'(MAX_STEPS))
            n_clamp = STEP_W'(MAX_STEPS);
        else
            n_clamp = steps_reg;

        cord_start = seg_acc || (state_reg == S_CORD_S && cord_done);
        cord_angle = (state_reg == S_IDLE) ? seg.data.start_heading : seg_reg.end_heading;

        base_idx = axis_reg ? 4'(AXIS_TERMS) : 4'd0;
        term_idx = base_idx + 4'd1 + 4'(op_reg[1:0]);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SEG:
            begin
                case (op_reg)
                    3'd0:    begin mul_a = MUL_W'(seg_reg.start_speed); mul_b = MUL_W'(sin_s_reg); end
                    3'd1:    begin mul_a = MUL_W'(seg_reg.start_speed); mul_b = MUL_W'(cos_s_reg); end
                    3'd2:    begin mul_a = MUL_W'(seg_reg.end_speed);   mul_b = MUL_W'(sin_e_reg); end
                    3'd3:    begin mul_a = MUL_W'(seg_reg.end_speed);   mul_b = MUL_W'(cos_e_reg); end
                    3'd4:    begin mul_a = MUL_W'(n_reg); mul_b = MUL_W'(n_reg); end
                    3'd5:    begin mul_a = uext(n2_reg); mul_b = uext(n2_reg); end
                    default: begin mul_a = uext(n4_reg); mul_b = MUL_W'(n_reg); end
                endcase
            end
            S_PT:
            begin
                case (op_reg)
                    3'd0:    begin mul_a = MUL_W'(idx_reg); mul_b = MUL_W'(idx_reg); end
                    3'd1:    begin mul_a = uext(pw_reg[0]); mul_b = MUL_W'(idx_reg); end
                    3'd2:    begin mul_a = uext(pw_reg[1]); mul_b = MUL_W'(idx_reg); end
                    3'd3:    begin mul_a = uext(pw_reg[2]); mul_b = MUL_W'(idx_reg); end
                    3'd4:    begin mul_a = MUL_W'(idx_reg); mul_b = uext(n4_reg); end
                    3'd5:    begin mul_a = uext(pw_reg[1]); mul_b = uext(n2_reg); end
                    default: begin mul_a = uext(pw_reg[2]); mul_b = MUL_W'(n_reg); end
                endcase
            end
            S_AXIS:
            begin
                mul_a = MUL_W'(coef_store[term_idx]);
                mul_b = uext(w_reg[op_reg[1:0]]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        acc_sum   = acc_reg + prod;
        div_start = state_reg == S_AXIS && ph_reg && op_reg == 3'd3;

        pt_sum = SUM_W'(coef_store[base_idx]) + SUM_W'(quo);
        if (pt_sum > SUM_W'(8388607))
            pt_sum = SUM_W'(8388607);
        else if (pt_sum < -SUM_W'(8388608))
            pt_sum = -SUM_W'(8388608);
        pt_sat = POS_W'(pt_sum);

        ux = (COEF_W'(seg_reg.end_x) - COEF_W'(seg_reg.start_x)) - sx(vel_reg[0]);
        vx = sx(vel_reg[2]) - sx(vel_reg[0]);
        uy = (COEF_W'(seg_reg.end_y) - COEF_W'(seg_reg.start_y)) - sx(vel_reg[1]);
        vy = sx(vel_reg[3]) - sx(vel_reg[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            steps_reg     <= steps_t'(STEPS_RESET);
            idx_reg       <= '0;
            op_reg        <= '0;
            ph_reg        <= 1'b0;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                steps_reg <= cfg.data;
            case (state_reg)
                S_IDLE:
                begin
                    if (seg_acc)
                        state_reg <= S_CORD_S;
                end
                S_CORD_S:
                begin
                    if (cord_done)
                        state_reg <= S_CORD_E;
                end
                S_CORD_E:
                begin
                    if (cord_done)
                    begin
                        op_reg    <= '0;
                        ph_reg    <= 1'b0;
                        state_reg <= S_SEG;
                    end
                end
                S_SEG:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        op_reg <= op_reg + 3'd1;
                        if (op_reg == 3'd6)
                            state_reg <= S_COEF;
                    end
                end
                S_COEF:
                begin
                    idx_reg   <= '0;
                    op_reg    <= '0;
                    ph_reg    <= 1'b0;
                    state_reg <= S_PT;
                end
                S_PT:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (op_reg == 3'd6)
                        begin
                            op_reg    <= '0;
                            axis_reg  <= 1'b0;
                            state_reg <= S_AXIS;
                        end
                        else
                            op_reg <= op_reg + 3'd1;
                    end
                end
                S_AXIS:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        op_reg <= op_reg + 3'd1;
                        if (op_reg == 3'd3)
                            state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        op_reg <= '0;
                        ph_reg <= 1'b0;
                        if (!axis_reg)
                        begin
                            axis_reg  <= 1'b1;
                            state_reg <= S_AXIS;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (pt.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            op_reg    <= '0;
                            ph_reg    <= 1'b0;
                            state_reg <= S_PT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_acc)
        begin
            seg_reg   <= seg.data;
            n_reg     <= n_clamp;
            count_reg <= seg.data.include_end ? IDX_W'(n_clamp) + 1'b1 : IDX_W'(n_clamp);
        end
        if (state_reg == S_CORD_S && cord_done)
        begin
            sin_s_reg <= cord_sin;
            cos_s_reg <= cord_cos;
        end
        if (state_reg == S_CORD_E && cord_done)
        begin
            sin_e_reg <= cord_sin;
            cos_e_reg <= cord_cos;
        end
        if (state_reg == S_SEG && ph_reg)
        begin
            case (op_reg)
                3'd0, 3'd1, 3'd2, 3'd3: vel_reg[op_reg[1:0]] <= round_vel(prod);
                3'd4:    n2_reg <= WGT_W'(prod);
                3'd5:    n4_reg <= WGT_W'(prod);
                default: n5_reg <= WGT_W'(prod);
            endcase
        end
        if (state_reg == S_COEF)
        begin
            coef_store[0] <= COEF_W'(seg_reg.start_x);
            coef_store[1] <= sx(vel_reg[0]);
            coef_store[2] <= (ux <<< 3) + (ux <<< 1) - (vx <<< 2);
            coef_store[3] <= (vx <<< 3) - vx - (ux <<< 4) + ux;
            coef_store[4] <= (ux <<< 2) + (ux <<< 1) - (vx <<< 1) - vx;
            coef_store[5] <= COEF_W'(seg_reg.start_y);
            coef_store[6] <= sx(vel_reg[1]);
            coef_store[7] <= (uy <<< 3) + (uy <<< 1) - (vy <<< 2);
            coef_store[8] <= (vy <<< 3) - vy - (uy <<< 4) + uy;
            coef_store[9] <= (uy <<< 2) + (uy <<< 1) - (vy <<< 1) - vy;
        end
        if (state_reg == S_PT && ph_reg)
        begin
            case (op_reg)
                3'd0:    pw_reg[0] <= WGT_W'(prod);
                3'd1:    pw_reg[1] <= WGT_W'(prod);
                3'd2:    pw_reg[2] <= WGT_W'(prod);
                3'd3:    w_reg[3]  <= WGT_W'(prod);
                3'd4:    w_reg[0]  <= WGT_W'(prod);
                3'd5:    w_reg[1]  <= WGT_W'(prod);
                default: w_reg[2]  <= WGT_W'(prod);
            endcase
        end
        if ((state_reg == S_PT && ph_reg && op_reg == 3'd6) ||
            (state_reg == S_DIV && div_done && !axis_reg))
            acc_reg <= '0;
        else if (state_reg == S_AXIS && ph_reg)
            acc_reg <= acc_sum;
        if (state_reg == S_DIV && div_done)
        begin
            if (!axis_reg)
                px_reg <= pt_sat;
            else
            begin
                py_reg   <= pt_sat;
                last_reg <= idx_reg == count_reg - 1'b1;
            end
        end
    end

    a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pt.valid |-> !seg.ready)
        else $error("point offered while a segment is being accepted");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (pt.valid && pt.ready && pt.data.last_point) |=> seg.ready)
        else $error("block not idle after the last point of a segment");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PT || state_reg == S_OUT) |-> (idx_reg < count_reg))
        else $error("point index beyond the segment's point count");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the quintic segment interpolator.
`timescale 1ns / 100ps

module tb_top;
    import qsi_pkg::*;

    localparam longint POS_MAX     = 8388607;
    localparam longint POS_MIN     = -8388608;
    localparam int     CYCLE_LIMIT = 20000000;

    localparam longint ATAN_TAB [CORDIC_ROUNDS] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qsi_stream_if #(.T(seg_t))   seg_if ();
    qsi_stream_if #(.T(point_t)) pt_if ();
    qsi_stream_if #(.T(steps_t)) cfg_if ();

    quintic_segment_interpolator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg_if),
        .pt    (pt_if),
        .cfg   (cfg_if)
    );

    seg_t   pending_segs [$];
    point_t expected_points [$];
    steps_t steps_reg = steps_t'(STEPS_RESET);
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     failed = 1'b0;
    int     cycle_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint div_nearest(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint sat_pos(longint v);
        return (v < POS_MIN) ? POS_MIN : ((v > POS_MAX) ? POS_MAX : v);
    endfunction

    function automatic longint clamp_trig(longint v);
        return (v < -TRIG_ONE) ? -TRIG_ONE : ((v > TRIG_ONE) ? TRIG_ONE : v);
    endfunction

    task automatic heading_trig(input longint ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint t;
        bit     flip;
        x = CORDIC_GAIN;
        y = 0;
        z = ang;
        flip = 1'b0;
        if (z > QUARTER_TURN)
        begin
            z -= HALF_TURN;
            flip = 1'b1;
        end
        else if (z < -QUARTER_TURN)
        begin
            z += HALF_TURN;
            flip = 1'b1;
        end
        for (int k = 0; k < CORDIC_ROUNDS; k++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> k);
                y = y + (x >>> k);
                z -= ATAN_TAB[k];
            end
            else
            begin
                t = x + (y >>> k);
                y = y - (x >>> k);
                z += ATAN_TAB[k];
            end
            x = t;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = clamp_trig(y);
        c = clamp_trig(x);
    endtask

    task automatic predict_points(input seg_t s);
        longint sin_s, cos_s, sin_e, cos_e;
        longint p0 [2];
        longint p1 [2];
        longint v0 [2];
        longint v1 [2];
        longint a3 [2];
        longint a4 [2];
        longint a5 [2];
        longint u, v, n, count, i, num, val;
        longint vs, ve;
        point_t pnt;
        heading_trig(longint'(s.start_heading), sin_s, cos_s);
        heading_trig(longint'(s.end_heading), sin_e, cos_e);
        vs = longint'({1'b0, s.start_speed});
        ve = longint'({1'b0, s.end_speed});
        p0[0] = longint'(s.start_x);
        p0[1] = longint'(s.start_y);
        p1[0] = longint'(s.end_x);
        p1[1] = longint'(s.end_y);
        v0[0] = div_nearest(vs * sin_s, TRIG_ONE);
        v0[1] = div_nearest(vs * cos_s, TRIG_ONE);
        v1[0] = div_nearest(ve * sin_e, TRIG_ONE);
        v1[1] = div_nearest(ve * cos_e, TRIG_ONE);
        for (int a = 0; a < 2; a++)
        begin
            u = (p1[a] - p0[a]) - v0[a];
            v = v1[a] - v0[a];
            a3[a] = 10 * u - 4 * v;
            a4[a] = -15 * u + 7 * v;
            a5[a] = 6 * u - 3 * v;
        end
        n = (steps_reg == 0) ? 1 : longint'(steps_reg);
        if (n > MAX_STEPS_DEF)
            n = MAX_STEPS_DEF;
        count = s.include_end ? n + 1 : n;
        for (i = 0; i < count; i++)
        begin
            for (int a = 0; a < 2; a++)
            begin
                num = v0[a] * i * n * n * n * n + a3[a] * i * i * i * n * n
                    + a4[a] * i * i * i * i * n + a5[a] * i * i * i * i * i;
                val = sat_pos(p0[a] + div_nearest(num, n * n * n * n * n));
                if (a == 0)
                    pnt.point_x = val[POS_W-1:0];
                else
                    pnt.point_y = val[POS_W-1:0];
            end
            pnt.last_point = (i == count - 1);
            expected_points = {expected_points, pnt};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_if.valid <= 1'b0;
            seg_if.data  <= '0;
        end
        else if (!seg_if.valid || seg_if.ready)
        begin
            if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                seg_if.valid <= 1'b1;
                seg_if.data  <= pending_segs.pop_front();
            end
            else
                seg_if.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pt_if.ready <= 1'b0;
        else
            pt_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                steps_reg = cfg_if.data;
            if (seg_if.valid && seg_if.ready)
                predict_points(seg_if.data);
            if (pt_if.valid && pt_if.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected point x=%0d y=%0d", pt_if.data.point_x,
                           pt_if.data.point_y);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (pt_if.data.point_x !== want.point_x)
                    begin
                        $error("point_x expected %0d actual %0d", want.point_x,
                               pt_if.data.point_x);
                        failed = 1'b1;
                    end
                    if (pt_if.data.point_y !== want.point_y)
                    begin
                        $error("point_y expected %0d actual %0d", want.point_y,
                               pt_if.data.point_y);
                        failed = 1'b1;
                    end
                    if (pt_if.data.last_point !== want.last_point)
                    begin
                        $error("last_point expected %0b actual %0b", want.last_point,
                               pt_if.data.last_point);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic seg_t make_seg(longint sx, longint sy, longint ex, longint ey,
                                      longint hs, longint he, longint vs, longint ve,
                                      bit last);
        seg_t s;
        s.start_x       = sx[POS_W-1:0];
        s.start_y       = sy[POS_W-1:0];
        s.end_x         = ex[POS_W-1:0];
        s.end_y         = ey[POS_W-1:0];
        s.start_heading = hs[ANG_W-1:0];
        s.end_heading   = he[ANG_W-1:0];
        s.start_speed   = vs[SPD_W-1:0];
        s.end_speed     = ve[SPD_W-1:0];
        s.include_end   = last;
        return s;
    endfunction

    function automatic seg_t random_seg();
        seg_t s;
        logic [191:0] bits;
        if ($urandom_range(1))
        begin
            bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom()};
            s = bits[$bits(seg_t)-1:0];
        end
        else
            s = make_seg($urandom_range(2097152) - 1048576, $urandom_range(2097152) - 1048576,
                         $urandom_range(2097152) - 1048576, $urandom_range(2097152) - 1048576,
                         $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                         $urandom_range(1048576), $urandom_range(1048576), 1'b0);
        s.include_end = $urandom_range(1);
        return s;
    endfunction

    task automatic write_steps(input int value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= steps_t'(value);
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_segs.size() > 0 || seg_if.valid || expected_points.size() > 0);
    endtask

    task automatic queue_seg(input seg_t s);
        pending_segs = {pending_segs, s};
    endtask

    initial
    begin
        int phase_steps [13];
        int phase_count [13];
        longint corner_ang [8];
        phase_steps = '{4, 1, 63, 0, 7, 3, 16, 2, 63, 5, 9, 1, 12};
        phase_count = '{0, 40, 4, 30, 40, 40, 20, 40, 4, 40, 30, 30, 22};
        corner_ang  = '{0, 32767, -32768, 16384, -16384, 16385, -16385, 8192};
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 13; p++)
        begin
            send_idle_pct = (p < 5) ? 16 : ((p < 9) ? 50 : 0);
            recv_idle_pct = (p < 5) ? 50 : ((p < 9) ? 16 : 0);
            write_steps(phase_steps[p]);
            if (p == 0)
            begin
                queue_seg(make_seg(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
                queue_seg(make_seg(POS_MAX, POS_MIN, POS_MIN, POS_MAX,
                                   0, 0, 0, 0, 1'b1));
                queue_seg(make_seg(POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                                   16384, 0, 16777215, 16777215, 1'b1));
                queue_seg(make_seg(POS_MIN, POS_MIN, POS_MIN, POS_MIN,
                                   -16384, -32768, 16777215, 16777215, 1'b0));
                for (int k = 0; k < 8; k++)
                    queue_seg(make_seg(0, 0, 65536, -65536, corner_ang[k],
                                       corner_ang[7 - k], 16777215, 65536, k[0]));
                for (int k = 0; k < 8; k++)
                    queue_seg(random_seg());
            end
            for (int k = 0; k < phase_count[p]; k++)
                queue_seg(random_seg());
            wait_drained();
        end
        repeat (300) @(posedge clk);
        if (!failed && expected_points.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
